// ----- sv/vsc_pkg.sv -----
// ----------------------------------------------------------------------------
// vsc_pkg
// Shared constants and types for the Vigenere byte stream cipher.
// ----------------------------------------------------------------------------
package vsc_pkg;

   // table geometry
   localparam int ALPHA_DEPTH = 256;
   localparam int BANK_COUNT  = 8;
   localparam int BANK_BITS   = $clog2(BANK_COUNT);
   localparam int ROW_COUNT   = ALPHA_DEPTH / BANK_COUNT;
   localparam int ROW_BITS    = $clog2(ROW_COUNT);
   localparam int KEY_DEPTH   = 64;
   localparam int KEY_BITS    = $clog2(KEY_DEPTH);

   typedef logic [7:0]          data_type;
   typedef logic [ROW_BITS-1:0] row_type;
   typedef logic [KEY_BITS-1:0] key_pos_type;

   // beat kinds on the request channel
   localparam logic [1:0] OP_WR_ALPHA = 2'd0;
   localparam logic [1:0] OP_WR_KEY   = 2'd1;
   localparam logic [1:0] OP_DATA     = 2'd2;

   // cipher modes
   localparam logic [2:0] MODE_ALPHA_ENC = 3'd0;
   localparam logic [2:0] MODE_ALPHA_DEC = 3'd1;
   localparam logic [2:0] MODE_BYTE_ADD  = 3'd2;
   localparam logic [2:0] MODE_BYTE_SUB  = 3'd3;
   localparam logic [2:0] MODE_XOR       = 3'd4;

   // register indexes
   localparam logic [1:0] REG_MODE      = 2'd0;
   localparam logic [1:0] REG_ALPHA_LEN = 2'd1;
   localparam logic [1:0] REG_KEY_LEN   = 2'd2;

   localparam logic [6:0] KEY_LEN_MAX = 7'(KEY_DEPTH);

endpackage

// ----- sv/vsc_ram.sv -----
// ----------------------------------------------------------------------------
// vsc_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/vigenere_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// vigenere_stream_cipher
// Byte stream Vigenere cipher with alphabet table, key ring and byte modes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per item: tuser is the kind (write alphabet entry,
//   write key byte, data byte), tdata holds table_index and byte_value, tlast
//   ends a message and sends the key position back to 0.
//   rsp_* returns one beat per data byte: tdata is the output byte, tuser is
//   set when the cipher rule was applied to it.
//   csr_* writes mode, alphabet length and key length; write only while idle.
// Timing:
//   Table writes are taken while idle. Byte modes pass each data byte through
//   S_KEY and S_OUT. Alphabet modes scan the alphabet eight entries per row
//   read, data and key byte searched together, up to the last alphabet row.
//   The scan rate is set by the single row read port of the eight-bank store.
//   One item is worked at a time; the output register lets a new item be
//   taken while the previous result waits for rsp_tready.
// Reset:
//   Synchronous reset clears the control state, key position and registers
//   (mode 0, lengths 1). Table contents stay undefined until written.
// ----------------------------------------------------------------------------
module vigenere_stream_cipher (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] table_index, [15:8] byte_value
   input  logic [1:0]  req_tuser,   // [1:0] operation
   input  logic        req_tlast,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] substituted
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_KEY   = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_MOD   = 3'd4;
   localparam logic [2:0] S_FETCH = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   // configuration registers
   logic [2:0] mode_ff;
   logic [7:0] alpha_len_ff;
   logic [6:0] key_len_ff;

   logic [2:0] state_ff, state_in;
   vsc_pkg::key_pos_type key_pos_ff, key_pos_in;
   vsc_pkg::data_type    val_ff, val_in;
   logic                 last_ff, last_in;
   vsc_pkg::data_type    key_ff, key_in;
   vsc_pkg::row_type     row_ff, row_in;
   vsc_pkg::row_type     cmp_row_ff;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic                 fnd_d_ff, fnd_d_in;
   logic                 fnd_k_ff, fnd_k_in;
   vsc_pkg::data_type    di_ff, di_in;
   vsc_pkg::data_type    ki_ff, ki_in;
   logic [vsc_pkg::BANK_BITS-1:0] sel_ff, sel_in;
   vsc_pkg::data_type    res_ff, res_in;
   logic                 sub_ff, sub_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   vsc_pkg::data_type    rsp_data_ff, rsp_data_in;
   logic                 rsp_sub_ff, rsp_sub_in;

   logic                 accept;
   logic [1:0]           req_op;
   vsc_pkg::data_type    req_idx;
   vsc_pkg::data_type    req_val;
   vsc_pkg::data_type    key_rdata;
   vsc_pkg::data_type    bank_rdata [vsc_pkg::BANK_COUNT];
   vsc_pkg::row_type     rd_row;
   vsc_pkg::row_type     last_row;
   logic [7:0]           alen_m1;
   logic [6:0]           klen;
   logic [6:0]           pos_next;
   logic [8:0]           sum;
   logic [8:0]           alen9;
   vsc_pkg::data_type    ni;
   vsc_pkg::data_type    ent_idx;
   logic [vsc_pkg::BANK_COUNT-1:0] hit_d, hit_k;
   logic [vsc_pkg::BANK_BITS-1:0]  enc_d, enc_k;

   assign req_op  = req_tuser;
   assign req_idx = req_tdata[7:0];
   assign req_val = req_tdata[15:8];
   assign accept  = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   // ---------------------------------------------------------------- storage
   vsc_ram #(
      .WIDTH (8),
      .DEPTH (vsc_pkg::KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (accept && req_op == vsc_pkg::OP_WR_KEY
                && req_idx < 8'(vsc_pkg::KEY_DEPTH)),
      .wr_addr (req_idx[vsc_pkg::KEY_BITS-1:0]),
      .wr_data (req_val),
      .rd_addr (key_pos_ff),
      .rd_data (key_rdata)
   );

   // alphabet stored as rows of eight entries, one bank per entry column
   for (genvar b = 0; b < vsc_pkg::BANK_COUNT; b++) begin : g_bank
      vsc_ram #(
         .WIDTH (8),
         .DEPTH (vsc_pkg::ROW_COUNT)
      ) u_alpha_ram (
         .clock   (clock),
         .wr_en   (accept && req_op == vsc_pkg::OP_WR_ALPHA
                   && req_idx[vsc_pkg::BANK_BITS-1:0] == vsc_pkg::BANK_BITS'(b)),
         .wr_addr (req_idx[7:vsc_pkg::BANK_BITS]),
         .wr_data (req_val),
         .rd_addr (rd_row),
         .rd_data (bank_rdata[b])
      );
   end

   // ---------------------------------------------------------------- compare
   always_comb begin
      hit_d = '0;
      hit_k = '0;
      enc_d = '0;
      enc_k = '0;
      ent_idx = '0;
      for (int j = 0; j < vsc_pkg::BANK_COUNT; j++) begin
         ent_idx  = {cmp_row_ff, vsc_pkg::BANK_BITS'(j)};
         hit_d[j] = (ent_idx < alpha_len_ff) && (bank_rdata[j] == val_ff);
         hit_k[j] = (ent_idx < alpha_len_ff) && (bank_rdata[j] == key_ff);
      end
      // lowest set bit wins
      for (int j = vsc_pkg::BANK_COUNT - 1; j >= 0; j--) begin
         if (hit_d[j]) begin
            enc_d = vsc_pkg::BANK_BITS'(j);
         end
         if (hit_k[j]) begin
            enc_k = vsc_pkg::BANK_BITS'(j);
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      alen_m1  = alpha_len_ff - 8'd1;
      last_row = alen_m1[7:vsc_pkg::BANK_BITS];
      if (key_len_ff == 7'd0) begin
         klen = 7'd1;
      end else if (key_len_ff > vsc_pkg::KEY_LEN_MAX) begin
         klen = vsc_pkg::KEY_LEN_MAX;
      end else begin
         klen = key_len_ff;
      end
      pos_next = {1'b0, key_pos_ff} + 7'd1;
      alen9 = {1'b0, alpha_len_ff};
      if (mode_ff == vsc_pkg::MODE_ALPHA_ENC) begin
         sum = {1'b0, di_ff} + {1'b0, ki_ff};
      end else begin
         sum = {1'b0, di_ff} + alen9 - {1'b0, ki_ff};
      end
      if (sum >= alen9) begin
         ni = 8'(sum - alen9);
      end else begin
         ni = sum[7:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      key_pos_in  = key_pos_ff;
      val_in      = val_ff;
      last_in     = last_ff;
      key_in      = key_ff;
      row_in      = row_ff;
      cmp_vld_in  = 1'b0;
      fnd_d_in    = fnd_d_ff;
      fnd_k_in    = fnd_k_ff;
      di_in       = di_ff;
      ki_in       = ki_ff;
      sel_in      = sel_ff;
      res_in      = res_ff;
      sub_in      = sub_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_sub_in  = rsp_sub_ff;
      rd_row      = row_ff;

      // fold a compared row into the first-match trackers
      if (cmp_vld_ff) begin
         if (!fnd_d_ff && |hit_d) begin
            fnd_d_in = 1'b1;
            di_in    = {cmp_row_ff, enc_d};
         end
         if (!fnd_k_ff && |hit_k) begin
            fnd_k_in = 1'b1;
            ki_in    = {cmp_row_ff, enc_k};
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && req_op == vsc_pkg::OP_DATA) begin
               val_in   = req_val;
               last_in  = req_tlast;
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            key_in   = key_rdata;
            res_in   = val_ff;
            sub_in   = 1'b0;
            fnd_d_in = 1'b0;
            fnd_k_in = 1'b0;
            row_in   = '0;
            if (last_ff || pos_next >= klen) begin
               key_pos_in = '0;
            end else begin
               key_pos_in = pos_next[vsc_pkg::KEY_BITS-1:0];
            end
            state_in = S_OUT;
            case (mode_ff)
               vsc_pkg::MODE_ALPHA_ENC, vsc_pkg::MODE_ALPHA_DEC: begin
                  if (alpha_len_ff != 8'd0) begin
                     state_in = S_SCAN;
                  end
               end
               vsc_pkg::MODE_BYTE_ADD: begin
                  res_in = val_ff + key_rdata;
                  sub_in = 1'b1;
               end
               vsc_pkg::MODE_BYTE_SUB: begin
                  res_in = val_ff - key_rdata;
                  sub_in = 1'b1;
               end
               vsc_pkg::MODE_XOR: begin
                  res_in = val_ff ^ key_rdata;
                  sub_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            cmp_vld_in = 1'b1;
            if (row_ff == last_row) begin
               state_in = S_DRAIN;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_MOD;
         end
         S_MOD: begin
            rd_row = ni[7:vsc_pkg::BANK_BITS];
            sel_in = ni[vsc_pkg::BANK_BITS-1:0];
            if (fnd_d_ff && fnd_k_ff) begin
               state_in = S_FETCH;
            end else begin
               state_in = S_OUT;
            end
         end
         S_FETCH: begin
            res_in   = bank_rdata[sel_ff];
            sub_in   = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = res_ff;
               rsp_sub_in  = sub_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_pos_ff   <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         mode_ff      <= vsc_pkg::MODE_ALPHA_ENC;
         alpha_len_ff <= 8'd1;
         key_len_ff   <= 7'd1;
      end else begin
         state_ff   <= state_in;
         key_pos_ff <= key_pos_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_we) begin
            case (csr_addr)
               vsc_pkg::REG_MODE:      mode_ff      <= csr_wdata[2:0];
               vsc_pkg::REG_ALPHA_LEN: alpha_len_ff <= csr_wdata;
               vsc_pkg::REG_KEY_LEN:   key_len_ff   <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      last_ff     <= last_in;
      key_ff      <= key_in;
      row_ff      <= row_in;
      cmp_row_ff  <= row_ff;
      fnd_d_ff    <= fnd_d_in;
      fnd_k_ff    <= fnd_k_in;
      di_ff       <= di_in;
      ki_ff       <= ki_in;
      sel_ff      <= sel_in;
      res_ff      <= res_in;
      sub_ff      <= sub_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sub_ff  <= rsp_sub_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sub_ff;

endmodule
